@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file of the bit packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked at the same edge as the antecedent.
`define DSBP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked at the edge after the antecedent.
`define DSBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dsbp_pkg.sv @@
// Types, codes and Deflate range tables of the symbol bit packer.
`default_nettype none

package dsbp_pkg;

    localparam logic [2:0] OP_LOAD_LITLEN = 3'd0;
    localparam logic [2:0] OP_LOAD_DIST   = 3'd1;
    localparam logic [2:0] OP_LITERAL     = 3'd2;
    localparam logic [2:0] OP_MATCH       = 3'd3;
    localparam logic [2:0] OP_END_BLOCK   = 3'd4;

    localparam int MAX_CODE_LEN = 15;

    localparam logic [8:0] END_SYMBOL       = 9'd256;
    localparam logic [9:0] FIRST_LEN_SYMBOL = 10'd257;

    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int ACC_BITS  = 32;
    localparam int CODE_BITS = 15;

    localparam int LEN_CODES  = 29;
    localparam int DIST_CODES = 30;

    localparam logic [8:0] LEN_BASE [LEN_CODES] = '{
        9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
        9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
        9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
    };
    localparam logic [2:0] LEN_EXTRA [LEN_CODES] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd0
    };
    localparam logic [15:0] DIST_BASE [DIST_CODES] = '{
        16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
        16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385, 16'd513,
        16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097, 16'd6145,
        16'd8193, 16'd12289, 16'd16385, 16'd24577
    };
    localparam logic [3:0] DIST_EXTRA [DIST_CODES] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
        4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
        4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
    };

    typedef logic [QCNT_W-1:0] qcount_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [8:0]  table_index;
        logic [14:0] code_value;
        logic [3:0]  code_length;
        logic [7:0]  literal_byte;
        logic [7:0]  length_less_three;
        logic [15:0] match_distance;
    } sym_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       block_done;
        logic       load_error;
    } octet_t;

    // One right-aligned bit string: a table entry or a run of extra bits.
    typedef struct packed {
        logic [3:0]           len;
        logic [CODE_BITS-1:0] bits;
    } code_t;

    typedef enum logic [1:0] {
        KIND_LITERAL,
        KIND_MATCH,
        KIND_END,
        KIND_ERROR
    } kind_t;

    typedef struct packed {
        kind_t           kind;
        logic [5:0]      total;
        code_t [3:0]     seg;
    } qentry_t;

    typedef struct packed {
        logic [4:0] sym;
        code_t      extra;
    } xcode_t;

    function automatic xcode_t len_class(input logic [7:0] less3);
        logic [8:0] len;
        xcode_t     r;
        len = 9'(less3) + 9'd3;
        r   = '0;
        for (int i = 0; i < LEN_CODES; i++) begin
            if (len >= LEN_BASE[i])
            begin
                r.sym        = 5'(i);
                r.extra.len  = 4'(LEN_EXTRA[i]);
                r.extra.bits = CODE_BITS'(len - LEN_BASE[i]);
            end
        end
        return r;
    endfunction

    function automatic xcode_t dist_class(input logic [15:0] d);
        logic [15:0] dd;
        xcode_t      r;
        dd = d;
        // clamp to the legal window range
        if (d == 16'd0)
        begin
            dd = 16'd1;
        end
        else if (d > 16'd32768)
        begin
            dd = 16'd32768;
        end
        r = '0;
        for (int i = 0; i < DIST_CODES; i++) begin
            if (dd >= DIST_BASE[i])
            begin
                r.sym        = 5'(i);
                r.extra.len  = DIST_EXTRA[i];
                r.extra.bits = CODE_BITS'(dd - DIST_BASE[i]);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/deflate_symbol_bit_packer_core.sv @@
// Top level of the Deflate symbol bit packer.
//
//   channel  dir  handshake                  word
//   sym      in   sym_valid / sym_stall      dsbp_pkg::sym_t
//   octet    out  octet_valid / octet_stall  dsbp_pkg::octet_t
//
// A token is classified and its table entries read from RAM, then it waits in a
// four-word queue; the packer appends one code or extra-bit segment per cycle while
// its bit buffer has room and sends at most one byte word per cycle.
// Loads write the tables when accepted. Reset clears the bit buffer and the queue;
// the code tables are not cleared and must be loaded before use.
// A stall on octet holds the output word; the queue fills and then sym stalls.
`default_nettype none

module deflate_symbol_bit_packer_core #(
    parameter int LITLEN_SYMBOLS = 286,
    parameter int DIST_SYMBOLS   = 30
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sym_valid,
    output logic             sym_stall,
    input  dsbp_pkg::sym_t   sym,
    output logic             octet_valid,
    input  logic             octet_stall,
    output dsbp_pkg::octet_t octet
);

    dsbp_pkg::qcount_t queue_count;
    logic              push;
    dsbp_pkg::qentry_t push_entry;
    logic              pop;
    dsbp_pkg::qentry_t head;
    logic              head_valid;

    dsbp_front #(
        .LITLEN_SYMBOLS (LITLEN_SYMBOLS),
        .DIST_SYMBOLS   (DIST_SYMBOLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sym_valid   (sym_valid),
        .sym_stall   (sym_stall),
        .sym         (sym),
        .queue_count (queue_count),
        .push        (push),
        .push_entry  (push_entry)
    );

    dsbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .count      (queue_count)
    );

    dsbp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .octet_valid (octet_valid),
        .octet_stall (octet_stall),
        .octet       (octet)
    );

endmodule

`default_nettype wire

@@ hdl/dsbp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dsbp_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 286
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/dsbp_front.sv @@
// Front end: accepts tokens, loads code tables, classifies matches, fills the queue.
`default_nettype none

module dsbp_front #(
    parameter int LITLEN_SYMBOLS = 286,
    parameter int DIST_SYMBOLS   = 30
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sym_valid,
    output logic              sym_stall,
    input  dsbp_pkg::sym_t    sym,
    input  dsbp_pkg::qcount_t queue_count,
    output logic              push,
    output dsbp_pkg::qentry_t push_entry
);

    localparam int LIT_AW  = $clog2(LITLEN_SYMBOLS > 1 ? LITLEN_SYMBOLS : 2);
    localparam int DIST_AW = $clog2(DIST_SYMBOLS > 1 ? DIST_SYMBOLS : 2);
    localparam int CW      = $bits(dsbp_pkg::code_t);
    localparam logic [9:0] LIT_LIMIT  = 10'(LITLEN_SYMBOLS);
    localparam logic [9:0] DIST_LIMIT = 10'(DIST_SYMBOLS);
    localparam int OCC_W = dsbp_pkg::QCNT_W + 1;

    logic                  accept;
    logic                  too_long;
    dsbp_pkg::xcode_t      lc;
    dsbp_pkg::xcode_t      dc;
    logic [9:0]            lit_sym;
    logic [14:0]           load_mask;
    dsbp_pkg::code_t       load_code;
    logic                  lit_we;
    logic                  dist_we;
    logic [LIT_AW-1:0]     lit_ra;
    logic [DIST_AW-1:0]    dist_ra;
    logic                  item;
    dsbp_pkg::kind_t       kind;
    logic                  lit_empty;
    logic                  dist_empty;
    logic [CW-1:0]         lit_rdata;
    logic [CW-1:0]         dist_rdata;

    logic                  b_valid_reg;
    dsbp_pkg::kind_t       b_kind_reg;
    dsbp_pkg::code_t       b_ext1_reg;
    dsbp_pkg::code_t       b_ext2_reg;
    logic                  b_lit_empty_reg;
    logic                  b_dist_empty_reg;

    dsbp_pkg::code_t       lit_code;
    dsbp_pkg::code_t       dist_code;
    dsbp_pkg::code_t [3:0] seg;

    // Hold off while the queue could not take the word already in flight.
    assign sym_stall = (OCC_W'(queue_count) + OCC_W'(b_valid_reg))
                       >= OCC_W'(dsbp_pkg::QUEUE_DEPTH);
    assign accept    = sym_valid && !sym_stall;

    assign lc        = dsbp_pkg::len_class(sym.length_less_three);
    assign dc        = dsbp_pkg::dist_class(sym.match_distance);
    assign lit_sym   = dsbp_pkg::FIRST_LEN_SYMBOL + 10'(lc.sym);
    assign too_long  = 32'(sym.code_length) > 32'(dsbp_pkg::MAX_CODE_LEN);
    assign load_mask = 15'((16'd1 << sym.code_length) - 16'd1);
    assign load_code = '{len: sym.code_length, bits: sym.code_value & load_mask};

    always_comb
    begin
        lit_we     = 1'b0;
        dist_we    = 1'b0;
        lit_ra     = '0;
        dist_ra    = '0;
        item       = 1'b0;
        kind       = dsbp_pkg::KIND_LITERAL;
        lit_empty  = 1'b0;
        dist_empty = 1'b1;
        unique case (sym.op)
            dsbp_pkg::OP_LOAD_LITLEN:
            begin
                if ({1'b0, sym.table_index} >= LIT_LIMIT || too_long)
                begin
                    item = 1'b1;
                    kind = dsbp_pkg::KIND_ERROR;
                end
                else
                begin
                    lit_we = 1'b1;
                end
            end
            dsbp_pkg::OP_LOAD_DIST:
            begin
                if ({1'b0, sym.table_index} >= DIST_LIMIT || too_long)
                begin
                    item = 1'b1;
                    kind = dsbp_pkg::KIND_ERROR;
                end
                else
                begin
                    dist_we = 1'b1;
                end
            end
            dsbp_pkg::OP_LITERAL:
            begin
                item   = 1'b1;
                kind   = dsbp_pkg::KIND_LITERAL;
                lit_ra = LIT_AW'(sym.literal_byte);
            end
            dsbp_pkg::OP_MATCH:
            begin
                item       = 1'b1;
                kind       = dsbp_pkg::KIND_MATCH;
                lit_ra     = lit_sym[LIT_AW-1:0];
                lit_empty  = lit_sym >= LIT_LIMIT;
                dist_ra    = DIST_AW'(dc.sym);
                dist_empty = 10'(dc.sym) >= DIST_LIMIT;
            end
            dsbp_pkg::OP_END_BLOCK:
            begin
                item   = 1'b1;
                kind   = dsbp_pkg::KIND_END;
                lit_ra = LIT_AW'(dsbp_pkg::END_SYMBOL);
            end
            default:
            begin
                item = 1'b0;
            end
        endcase
    end

    dsbp_ram #(
        .WIDTH (CW),
        .DEPTH (LITLEN_SYMBOLS)
    ) u_litlen_ram (
        .clk   (clk),
        .we    (accept && lit_we),
        .waddr (LIT_AW'(sym.table_index)),
        .wdata (load_code),
        .raddr (lit_ra),
        .rdata (lit_rdata)
    );

    dsbp_ram #(
        .WIDTH (CW),
        .DEPTH (DIST_SYMBOLS)
    ) u_dist_ram (
        .clk   (clk),
        .we    (accept && dist_we),
        .waddr (DIST_AW'(sym.table_index)),
        .wdata (load_code),
        .raddr (dist_ra),
        .rdata (dist_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= accept && item;
        end
    end

    always_ff @(posedge clk)
    begin
        b_kind_reg       <= kind;
        b_ext1_reg       <= lc.extra;
        b_ext2_reg       <= dc.extra;
        b_lit_empty_reg  <= lit_empty;
        b_dist_empty_reg <= dist_empty;
    end

    // Table data is registered: it arrives in the cycle after the read address.
    assign lit_code  = b_lit_empty_reg  ? '0 : dsbp_pkg::code_t'(lit_rdata);
    assign dist_code = b_dist_empty_reg ? '0 : dsbp_pkg::code_t'(dist_rdata);

    always_comb
    begin
        seg = '0;
        case (b_kind_reg) inside
            dsbp_pkg::KIND_MATCH:
            begin
                seg[0] = lit_code;
                seg[1] = b_ext1_reg;
                seg[2] = dist_code;
                seg[3] = b_ext2_reg;
            end
            dsbp_pkg::KIND_LITERAL, dsbp_pkg::KIND_END:
            begin
                seg[0] = lit_code;
            end
            default:
            begin
                seg = '0;
            end
        endcase
    end

    assign push             = b_valid_reg;
    assign push_entry.kind  = b_kind_reg;
    assign push_entry.seg   = seg;
    assign push_entry.total = 6'(seg[0].len) + 6'(seg[1].len)
                            + 6'(seg[2].len) + 6'(seg[3].len);

endmodule

`default_nettype wire

@@ hdl/dsbp_queue.sv @@
// Short queue of classified tokens between the front end and the bit packer.
`default_nettype none

module dsbp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dsbp_pkg::qentry_t push_entry,
    input  logic              pop,
    output dsbp_pkg::qentry_t head,
    output logic              head_valid,
    output dsbp_pkg::qcount_t count
);

    localparam int PTR_W = $clog2(dsbp_pkg::QUEUE_DEPTH);

    dsbp_pkg::qentry_t slot_reg [dsbp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    dsbp_pkg::qcount_t count_reg;
    dsbp_pkg::qcount_t count_next;

    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign count_next  = count_reg + dsbp_pkg::QCNT_W'(push) - dsbp_pkg::QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = count_reg != '0;
    assign count      = count_reg;

endmodule

`default_nettype wire

@@ hdl/dsbp_back.sv @@
// Back end: packs code segments MSB-first into bytes and drives the output register.
`default_nettype none

module dsbp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  dsbp_pkg::qentry_t head,
    input  logic              head_valid,
    output logic              pop,
    output logic              octet_valid,
    input  logic              octet_stall,
    output dsbp_pkg::octet_t  octet
);

    localparam int AW      = dsbp_pkg::ACC_BITS;
    localparam int CB      = dsbp_pkg::CODE_BITS;
    localparam logic [5:0] APPEND_MAX = 6'(AW - CB);

    logic [AW-1:0]    acc_reg;
    logic [AW-1:0]    acc_next;
    logic [AW-1:0]    acc_mid;
    logic [AW-1:0]    ins;
    logic [5:0]       cnt_reg;
    logic [5:0]       cnt_next;
    logic [5:0]       cnt_mid;
    logic [5:0]       shamt;
    logic [2:0]       seg_idx_reg;
    logic [2:0]       seg_idx_next;
    logic [2:0]       seg_idx_step;
    logic [2:0]       nseg;
    logic [5:0]       used_reg;
    logic [5:0]       used_next;
    logic [5:0]       rem;
    logic [6:0]       span;
    dsbp_pkg::code_t  seg;
    logic             out_valid_reg;
    logic             out_valid_next;
    dsbp_pkg::octet_t out_reg;
    dsbp_pkg::octet_t out_next;
    logic             out_free;
    logic             is_err;
    logic             is_end;
    logic             segs_done;
    logic             emit_norm;
    logic             flush;
    logic             err_emit;
    logic             app;
    logic             last_norm;

    always_comb
    begin
        case (head.kind) inside
            dsbp_pkg::KIND_MATCH: nseg = 3'd4;
            dsbp_pkg::KIND_ERROR: nseg = 3'd0;
            default:              nseg = 3'd1;
        endcase
    end

    assign is_err    = head_valid && head.kind == dsbp_pkg::KIND_ERROR;
    assign is_end    = head.kind == dsbp_pkg::KIND_END;
    assign segs_done = seg_idx_reg == nseg;
    assign rem       = head.total - used_reg;
    // Bits still owed by the head token, counting those already buffered.
    assign span      = 7'(cnt_reg) + 7'(rem);
    assign last_norm = is_end ? span == 7'd8 : span < 7'd16;

    assign out_free  = !out_valid_reg || !octet_stall;
    assign emit_norm = out_free && cnt_reg >= 6'd8;
    assign flush     = out_free && head_valid && is_end && segs_done
                       && cnt_reg != 6'd0 && cnt_reg < 6'd8;
    assign err_emit  = out_free && is_err;

    assign cnt_mid = emit_norm ? cnt_reg - 6'd8 : cnt_reg;
    assign acc_mid = emit_norm ? acc_reg << 8 : acc_reg;

    assign seg   = head.seg[seg_idx_reg[1:0]];
    assign app   = head_valid && !segs_done && cnt_mid <= APPEND_MAX;
    assign shamt = 6'(AW) - cnt_mid - 6'(seg.len);
    assign ins   = {{(AW - CB){1'b0}}, seg.bits} << shamt;

    assign acc_next = flush ? '0 : (app ? (acc_mid | ins) : acc_mid);
    assign cnt_next = flush ? '0 : (app ? cnt_mid + 6'(seg.len) : cnt_mid);

    assign seg_idx_step = app ? seg_idx_reg + 3'd1 : seg_idx_reg;

    // Retire the token once every byte ending in its bits has gone out.
    assign pop = head_valid && (is_err ? err_emit
                 : (seg_idx_step == nseg
                    && (is_end ? cnt_next == 6'd0 : cnt_next < 6'd8)));

    assign seg_idx_next = pop ? '0 : seg_idx_step;
    assign used_next    = pop ? '0 : (app ? used_reg + 6'(seg.len) : used_reg);

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_free;
        if (emit_norm)
        begin
            out_valid_next = 1'b1;
            out_next       = '{out_byte: acc_reg[AW-1 -: 8], last_of_run: last_norm,
                               block_done: is_end && last_norm, load_error: 1'b0};
        end
        else if (flush)
        begin
            out_valid_next = 1'b1;
            out_next       = '{out_byte: acc_reg[AW-1 -: 8], last_of_run: 1'b1,
                               block_done: 1'b1, load_error: 1'b0};
        end
        else if (err_emit)
        begin
            out_valid_next = 1'b1;
            out_next       = '{out_byte: 8'd0, last_of_run: 1'b1,
                               block_done: 1'b0, load_error: 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            seg_idx_reg   <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            seg_idx_reg   <= seg_idx_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign octet_valid = out_valid_reg;
    assign octet       = out_reg;

endmodule

`default_nettype wire

@@ hdl/dsbp_checker.sv @@
// Port-level checks on the output words of the bit packer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module dsbp_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             octet_valid,
    input logic             octet_stall,
    input dsbp_pkg::octet_t octet
);

    `DSBP_ASSERT_NEXT(a_stall_hold, octet_valid && octet_stall, octet_valid && $stable(octet), "stalled output word changed")
    `DSBP_ASSERT_SAME(a_err_word, octet_valid && octet.load_error, octet.out_byte == 8'd0 && octet.last_of_run && !octet.block_done, "load error word malformed")
    `DSBP_ASSERT_SAME(a_done_last, octet_valid && octet.block_done, octet.last_of_run && !octet.load_error, "block end word not last of its token")

endmodule

bind deflate_symbol_bit_packer_core dsbp_checker u_dsbp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .octet_valid (octet_valid),
    .octet_stall (octet_stall),
    .octet       (octet)
);

`default_nettype wire

@@ test/dsbp_checker.sv @@
// Checker of the bit packer: predicts the byte words of each token and compares them.
module dsbp_scoreboard #(
    parameter int LITLEN_N = 286,
    parameter int DIST_N   = 30
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sym_valid,
    input  logic             sym_stall,
    input  dsbp_pkg::sym_t   sym,
    input  logic             octet_valid,
    input  logic             octet_stall,
    input  dsbp_pkg::octet_t octet,
    output int               errors,
    output int               owed,
    output int               words_out
);
    import dsbp_pkg::*;

    code_t      litlen_tab [LITLEN_N];
    code_t      dist_tab [DIST_N];
    logic [7:0] acc_bits  = '0;
    int         acc_count = 0;
    logic [7:0] fresh [$];
    octet_t     octets_due [$];
    int         bad   = 0;
    int         taken = 0;

    function automatic int len_xbits(input int slot);
        return (slot < 8 || slot == 28) ? 0 : (slot - 4) / 4;
    endfunction

    function automatic int len_floor(input int slot);
        int base;
        base = 3;
        if (slot == 28)
        begin
            return 258;
        end
        for (int j = 0; j < slot; j++) begin
            base += 1 << len_xbits(j);
        end
        return base;
    endfunction

    function automatic int dist_xbits(input int slot);
        return (slot < 4) ? 0 : (slot - 2) / 2;
    endfunction

    function automatic int dist_floor(input int slot);
        int base;
        base = 1;
        for (int j = 0; j < slot; j++) begin
            base += 1 << dist_xbits(j);
        end
        return base;
    endfunction

    // Shift bits in MSB first; hand over each full byte.
    task pack_bits(input logic [14:0] value, input int count);
        for (int i = count - 1; i >= 0; i--) begin
            acc_bits = {acc_bits[6:0], value[i]};
            acc_count++;
            if (acc_count == 8)
            begin
                fresh.insert(fresh.size(), acc_bits);
                acc_bits  = '0;
                acc_count = 0;
            end
        end
    endtask

    task predict_words(input sym_t s);
        int         limit;
        int         span;
        int         back_dist;
        int         li;
        int         di;
        logic [14:0] mask;
        logic [7:0] padded;
        code_t      e;
        octet_t     w;
        fresh.delete();
        case (s.op)
            OP_LOAD_LITLEN, OP_LOAD_DIST:
            begin
                limit = (s.op == OP_LOAD_LITLEN) ? LITLEN_N : DIST_N;
                if (int'(s.table_index) >= limit || int'(s.code_length) > MAX_CODE_LEN)
                begin
                    w.out_byte    = 8'h00;
                    w.last_of_run = 1'b1;
                    w.block_done  = 1'b0;
                    w.load_error  = 1'b1;
                    octets_due.insert(octets_due.size(), w);
                end
                else
                begin
                    mask   = 15'h7fff >> (15 - int'(s.code_length));
                    e.len  = s.code_length;
                    e.bits = s.code_value & mask;
                    if (s.op == OP_LOAD_LITLEN)
                    begin
                        litlen_tab[s.table_index] = e;
                    end
                    else
                    begin
                        dist_tab[s.table_index] = e;
                    end
                end
            end
            OP_LITERAL:
            begin
                e = litlen_tab[s.literal_byte];
                pack_bits(e.bits, int'(e.len));
            end
            OP_MATCH:
            begin
                span      = int'(s.length_less_three) + 3;
                back_dist = int'(s.match_distance);
                if (back_dist == 0)
                begin
                    back_dist = 1;
                end
                if (back_dist > 32768)
                begin
                    back_dist = 32768;
                end
                li = 0;
                for (int i = 0; i < 29; i++) begin
                    if (span >= len_floor(i))
                    begin
                        li = i;
                    end
                end
                di = 0;
                for (int i = 0; i < 30; i++) begin
                    if (back_dist >= dist_floor(i))
                    begin
                        di = i;
                    end
                end
                e = litlen_tab[int'(FIRST_LEN_SYMBOL) + li];
                pack_bits(e.bits, int'(e.len));
                pack_bits(15'(span - len_floor(li)), len_xbits(li));
                e = dist_tab[di];
                pack_bits(e.bits, int'(e.len));
                pack_bits(15'(back_dist - dist_floor(di)), dist_xbits(di));
            end
            OP_END_BLOCK:
            begin
                e = litlen_tab[END_SYMBOL];
                pack_bits(e.bits, int'(e.len));
                // pad the partial byte with zeros
                if (acc_count > 0)
                begin
                    padded = acc_bits << (8 - acc_count);
                    fresh.insert(fresh.size(), padded);
                end
                acc_bits  = '0;
                acc_count = 0;
            end
            default:
            begin
            end
        endcase
        foreach (fresh[i]) begin
            w.out_byte    = fresh[i];
            w.last_of_run = (i == fresh.size() - 1);
            w.block_done  = (i == fresh.size() - 1) && (s.op == OP_END_BLOCK);
            w.load_error  = 1'b0;
            octets_due.insert(octets_due.size(), w);
        end
    endtask

    task check_word(input octet_t got);
        octet_t want;
        if (octets_due.size() == 0)
        begin
            $error("octet word %h arrived with nothing expected", got);
            bad++;
        end
        else
        begin
            want = octets_due.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                bad++;
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                $error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
                bad++;
            end
            if (got.block_done !== want.block_done)
            begin
                $error("block_done: expected %b, got %b", want.block_done, got.block_done);
                bad++;
            end
            if (got.load_error !== want.load_error)
            begin
                $error("load_error: expected %b, got %b", want.load_error, got.load_error);
                bad++;
            end
        end
    endtask

    initial
    begin
        foreach (litlen_tab[i]) begin
            litlen_tab[i] = '0;
        end
        foreach (dist_tab[i]) begin
            dist_tab[i] = '0;
        end
    end

    // Predict before compare: a token's words never leave on the edge that takes it.
    always @(posedge clk) begin
        if (rst_n)
        begin
            if (sym_valid && !sym_stall)
            begin
                predict_words(sym);
            end
            if (octet_valid && !octet_stall)
            begin
                check_word(octet);
                taken++;
            end
        end
        errors    <= bad;
        owed      <= octets_due.size();
        words_out <= taken;
    end

endmodule

@@ test/tb_top.sv @@
// Testbench top of the bit packer: stimulus, output back-pressure and verdict.
module tb_top;
    import dsbp_pkg::*;

    localparam int LITLEN_N     = 286;
    localparam int DIST_N       = 30;
    localparam int LIT_POOL     = 16;
    localparam int RANDOM_ITEMS = 128;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   sym_valid   = 1'b0;
    sym_t   sym         = '0;
    logic   octet_stall = 1'b0;
    logic   sym_stall;
    logic   octet_valid;
    octet_t octet;

    int fail_count;
    int owed;
    int words_out;
    int cycles     = 0;
    int stall_left = 0;
    int calm_left  = 0;
    int pick;
    int calm_items = 0;
    int n_loads    = 0;
    int n_rejects  = 0;
    int n_literals = 0;
    int n_matches  = 0;
    int n_ends     = 0;
    int n_spare    = 0;

    always #1 clk = ~clk;

    deflate_symbol_bit_packer_core #(
        .LITLEN_SYMBOLS(LITLEN_N),
        .DIST_SYMBOLS  (DIST_N)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sym_valid  (sym_valid),
        .sym_stall  (sym_stall),
        .sym        (sym),
        .octet_valid(octet_valid),
        .octet_stall(octet_stall),
        .octet      (octet)
    );

    dsbp_scoreboard #(
        .LITLEN_N(LITLEN_N),
        .DIST_N  (DIST_N)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .sym_valid  (sym_valid),
        .sym_stall  (sym_stall),
        .sym        (sym),
        .octet_valid(octet_valid),
        .octet_stall(octet_stall),
        .octet      (octet),
        .errors     (fail_count),
        .owed       (owed),
        .words_out  (words_out)
    );

    // Back-pressure: short random stalls, a few long holds, and calm stretches.
    always @(posedge clk) begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left  <= stall_left - 1;
                octet_stall <= 1'b1;
            end
            else if (calm_left > 0)
            begin
                calm_left   <= calm_left - 1;
                octet_stall <= 1'b0;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    calm_left   <= $urandom_range(20, 80);
                    octet_stall <= 1'b0;
                end
                else if (pick < 12)
                begin
                    stall_left  <= $urandom_range(10, 40);
                    octet_stall <= 1'b1;
                end
                else if (pick < 40)
                begin
                    stall_left  <= $urandom_range(0, 2);
                    octet_stall <= 1'b1;
                end
                else
                begin
                    octet_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        if (calm_items > 0)
        begin
            calm_items--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            calm_items = $urandom_range(10, 30);
            return 0;
        end
        if (r < 50)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 95)
        begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(15, 40);
    endfunction

    // Hold the word until taken; keep valid high when the next word follows at once.
    task send(input sym_t s);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            sym_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sym       <= s;
        sym_valid <= 1'b1;
        @(posedge clk);
        while (sym_stall) @(posedge clk);
        case (s.op)
            OP_LOAD_LITLEN, OP_LOAD_DIST:
            begin
                n_loads++;
                if (int'(s.table_index) >= ((s.op == OP_LOAD_LITLEN) ? LITLEN_N : DIST_N))
                begin
                    n_rejects++;
                end
            end
            OP_LITERAL:   n_literals++;
            OP_MATCH:     n_matches++;
            OP_END_BLOCK: n_ends++;
            default:      n_spare++;
        endcase
    endtask

    // Random filler in every field; callers then set what the op uses.
    function automatic sym_t token(input logic [2:0] op);
        sym_t s;
        s    = 63'({$urandom, $urandom});
        s.op = op;
        return s;
    endfunction

    task load_code(input logic [2:0] op, input int idx, input int len, input int code);
        sym_t s;
        s             = token(op);
        s.table_index = 9'(idx);
        s.code_length = 4'(len);
        s.code_value  = 15'(code);
        send(s);
    endtask

    task literal(input int b);
        sym_t s;
        s              = token(OP_LITERAL);
        s.literal_byte = 8'(b);
        send(s);
    endtask

    task match(input int less3, input int back_dist);
        sym_t s;
        s                   = token(OP_MATCH);
        s.length_less_three = 8'(less3);
        s.match_distance    = 16'(back_dist);
        send(s);
    endtask

    function automatic int random_distance();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(32769, 65535);
            2:       return $urandom_range(1, 4);
            default: return $urandom_range(1, 1 << $urandom_range(1, 15));
        endcase
    endfunction

    initial
    begin
        int   r;
        logic [2:0] op;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load the literal pool, end and length symbols and every distance code;
        // some symbols stay unused.
        for (int i = 0; i < LIT_POOL; i++) begin
            load_code(OP_LOAD_LITLEN, i,
                      ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 15), $urandom);
        end
        for (int i = int'(END_SYMBOL); i < LITLEN_N; i++) begin
            load_code(OP_LOAD_LITLEN, i,
                      ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 15), $urandom);
        end
        for (int i = 0; i < DIST_N; i++) begin
            load_code(OP_LOAD_DIST, i,
                      ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 15), $urandom);
        end

        // Directed: empty end of block, masked code bits, field extremes, rejects.
        load_code(OP_LOAD_LITLEN, int'(END_SYMBOL), 0, 15'h7fff);
        send(token(OP_END_BLOCK));
        load_code(OP_LOAD_LITLEN, int'(END_SYMBOL), 7, 15'h7fff);
        load_code(OP_LOAD_LITLEN, 0, 15, 15'h5555);
        load_code(OP_LOAD_LITLEN, 255, 1, 15'h7ffe);
        load_code(OP_LOAD_LITLEN, 65, 0, 15'h7fff);
        literal(0);
        literal(255);
        literal(65);
        match(0, 1);
        match(255, 32768);
        match(254, 24577);
        match(8, 0);
        match(223, 65535);
        match(224, 32769);
        send(token(OP_END_BLOCK));
        send(token(OP_END_BLOCK));
        load_code(OP_LOAD_LITLEN, LITLEN_N, 5, 15'h001f);
        load_code(OP_LOAD_LITLEN, 511, 15, 15'h7fff);
        load_code(OP_LOAD_DIST, DIST_N, 3, 15'h0005);
        load_code(OP_LOAD_DIST, DIST_N - 1, 0, 15'h7fff);
        match(100, 30000);
        load_code(OP_LOAD_DIST, DIST_N - 1, 15, 15'h7fff);
        for (int k = int'(OP_SPARE_FIRST); k <= int'(OP_SPARE_LAST); k++) begin
            send(token(3'(k)));
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            op = ($urandom_range(0, 1) == 1) ? OP_LOAD_DIST : OP_LOAD_LITLEN;
            if (r < 38)
            begin
                literal($urandom_range(0, LIT_POOL - 1));
            end
            else if (r < 68)
            begin
                match($urandom_range(0, ($urandom_range(0, 1) == 1) ? 255 : 15),
                      random_distance());
            end
            else if (r < 78)
            begin
                send(token(OP_END_BLOCK));
            end
            else if (r < 88)
            begin
                load_code(op, $urandom_range(0, ((op == OP_LOAD_LITLEN) ? LITLEN_N : DIST_N) - 1),
                          $urandom_range(0, 15), $urandom);
            end
            else if (r < 95)
            begin
                load_code(op, $urandom_range((op == OP_LOAD_LITLEN) ? LITLEN_N : DIST_N, 511),
                          $urandom_range(0, 15), $urandom);
            end
            else
            begin
                send(token(3'($urandom_range(int'(OP_SPARE_FIRST), int'(OP_SPARE_LAST)))));
            end
        end
        send(token(OP_END_BLOCK));
        sym_valid <= 1'b0;

        // Drain: let the last token's words arrive, then watch for strays.
        @(posedge clk);
        while (owed != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (owed != 0)
        begin
            $error("%0d expected octet words never arrived", owed);
        end
        $display("Ran %0d table loads (%0d rejected), %0d literals, %0d matches,",
                 n_loads, n_rejects, n_literals, n_matches);
        $display("%0d block ends and %0d reserved ops; %0d octet words checked.",
                 n_ends, n_spare, words_out);
        if (fail_count == 0 && owed == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
